/* rtl/core/gbns_pkg.sv */
// shared types and constants of the go-back-n sender window
`default_nettype none

package gbns_pkg;

  // payload chunk size, a power of two so the file split is a shift and a mask
  localparam int PAYLOAD_BYTES = 1024;
  localparam int PAYLOAD_SHIFT = $clog2(PAYLOAD_BYTES);
  localparam int MAX_WINDOW    = 64;

  localparam int SEQ_W    = 31;
  localparam int SIZE_W   = 11;
  localparam int CHUNK_W  = 21;
  localparam int COUNT_W  = 22;
  localparam int WIN_W    = 7;
  localparam int REQ_W    = 2;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  // request codes
  localparam logic [REQ_W-1:0] REQ_SETUP   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ACK     = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TIMEOUT = 2'd2;
  localparam logic [REQ_W-1:0] REQ_FIN     = 2'd3;

  // packet kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_FIN  = 1'b1;

  // register indexes
  localparam logic REG_WINDOW_SIZE = 1'b0;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SEND = 2'd1,
    PH_FIN  = 2'd2
  } gbns_phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ACK,
    ST_ADVANCE,
    ST_SEND_FIN
  } gbns_state_t;

  typedef struct packed {
    logic load_in;
    logic do_setup;
    logic calc_diff;
    logic do_ack;
    logic do_rewind;
    logic emit_data;
    logic emit_fin;
    logic go_idle;
  } gbns_cmd_t;

  typedef struct packed {
    gbns_phase_t      phase;
    logic [REQ_W-1:0] req;
    logic             all_acked;
    logic             can_send;
    logic             send_last;
    logic             out_free;
  } gbns_status_t;

endpackage

`default_nettype wire

/* rtl/core/gbns_ctrl.sv */
// controller state machine of the go-back-n sender window
`default_nettype none

module gbns_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  gbns_pkg::gbns_status_t status,
  output gbns_pkg::gbns_cmd_t    cmd
);
  import gbns_pkg::*;

  gbns_state_t state;
  gbns_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        state_next = ST_IDLE;
        case (status.phase)
          PH_IDLE: begin
            if (status.req == REQ_SETUP) state_next = ST_ADVANCE;
          end
          PH_SEND: begin
            if (status.req == REQ_ACK) state_next = ST_ACK;
            else if (status.req == REQ_TIMEOUT || status.req == REQ_FIN)
              state_next = ST_ADVANCE;
          end
          PH_FIN: begin
            if (status.req == REQ_TIMEOUT) state_next = ST_SEND_FIN;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_ACK: state_next = ST_ADVANCE;
      ST_ADVANCE: begin
        if (status.all_acked) begin
          if (status.out_free) state_next = ST_IDLE;
        end else if (status.can_send) begin
          if (status.out_free && status.send_last) state_next = ST_IDLE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SEND_FIN: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        // nothing is taken in while reset is held
        in_stall    = rst;
        cmd.load_in = in_valid && !rst;
      end
      ST_DECODE: begin
        case (status.phase)
          PH_IDLE: cmd.do_setup = (status.req == REQ_SETUP);
          PH_SEND: begin
            cmd.calc_diff = (status.req == REQ_ACK);
            cmd.do_rewind = (status.req == REQ_TIMEOUT);
          end
          PH_FIN:  cmd.go_idle = (status.req == REQ_FIN);
          default: cmd = '0;
        endcase
      end
      ST_ACK: cmd.do_ack = 1'b1;
      ST_ADVANCE: begin
        if (status.all_acked) cmd.emit_fin = status.out_free;
        else if (status.can_send) cmd.emit_data = status.out_free;
      end
      ST_SEND_FIN: cmd.emit_fin = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/gbns_dp.sv */
// window state, sequence arithmetic and output register of the go-back-n sender
`default_nettype none

module gbns_dp #(
  parameter int MAX_WIN = gbns_pkg::MAX_WINDOW
) (
  input  wire                              clk,
  input  wire                              rst,
  input  gbns_pkg::gbns_cmd_t              cmd,
  output gbns_pkg::gbns_status_t           status,
  input  wire                              cfg_we,
  input  wire  [gbns_pkg::WIN_W-1:0]       cfg_wdata,
  output logic [gbns_pkg::WIN_W-1:0]       window_size,
  input  wire  [gbns_pkg::REQ_W-1:0]       req_type,
  input  wire  [gbns_pkg::SEQ_W-1:0]       seq,
  input  wire  [gbns_pkg::SEQ_W-1:0]       xfer_len,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             pkt_kind,
  output logic [gbns_pkg::SEQ_W-1:0]       seq_out,
  output logic [gbns_pkg::CHUNK_W-1:0]     chunk_index,
  output logic [gbns_pkg::SIZE_W-1:0]      pay_len,
  output logic                             last
);
  import gbns_pkg::*;

  // latched transaction
  logic [REQ_W-1:0]   req_r;
  logic [SEQ_W-1:0]   seq_r;
  logic [SEQ_W-1:0]   fsize_r;

  // window state
  gbns_phase_t        phase;
  logic [COUNT_W-1:0] total_chunks;
  logic [COUNT_W-1:0] acked_count;
  logic [WIN_W-1:0]   outstanding_count;
  logic [SEQ_W-1:0]   next_seq;
  logic [SEQ_W-1:0]   expected_seq;
  logic [SIZE_W-1:0]  tail_size;
  logic [SEQ_W-1:0]   ack_diff;

  logic [WIN_W-1:0]         eff_win;
  logic [PAYLOAD_SHIFT-1:0] rem;
  logic                     rem_nz;
  logic [COUNT_W-1:0]       chunk;
  logic [COUNT_W:0]         chunk_inc;
  logic                     more_chunks;
  logic [WIN_W:0]           out_inc;
  logic                     in_range;
  logic [WIN_W-1:0]         ack_step;
  logic [SIZE_W-1:0]        chunk_size;

  always_comb begin
    if (window_size == '0) eff_win = WIN_W'(1);
    else if (window_size > WIN_W'(MAX_WIN)) eff_win = WIN_W'(MAX_WIN);
    else eff_win = window_size;
  end

  assign rem         = fsize_r[PAYLOAD_SHIFT-1:0];
  assign rem_nz      = (rem != '0);
  assign chunk       = acked_count + COUNT_W'(outstanding_count);
  assign chunk_inc   = {1'b0, chunk} + (COUNT_W+1)'(1);
  assign more_chunks = (chunk_inc < {1'b0, total_chunks});
  assign out_inc     = {1'b0, outstanding_count} + (WIN_W+1)'(1);
  assign in_range    = (ack_diff < SEQ_W'(outstanding_count));
  assign ack_step    = ack_diff[WIN_W-1:0] + WIN_W'(1);
  assign chunk_size  = more_chunks ? SIZE_W'(PAYLOAD_BYTES) : tail_size;

  always_comb begin
    status.phase     = phase;
    status.req       = req_r;
    status.all_acked = (acked_count >= total_chunks);
    status.can_send  = (outstanding_count < eff_win) && (chunk < total_chunks);
    status.send_last = !((out_inc < {1'b0, eff_win}) && more_chunks);
    status.out_free  = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_r   <= req_type;
      seq_r   <= seq;
      fsize_r <= xfer_len;
    end
    if (cmd.calc_diff) ack_diff <= seq_r - expected_seq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size       <= WIN_W'(1);
      phase             <= PH_IDLE;
      total_chunks      <= '0;
      acked_count       <= '0;
      outstanding_count <= '0;
      next_seq          <= '0;
      expected_seq      <= '0;
      tail_size         <= '0;
    end else begin
      if (cfg_we) window_size <= cfg_wdata;
      if (cmd.do_setup) begin
        total_chunks      <= COUNT_W'(fsize_r >> PAYLOAD_SHIFT) + COUNT_W'(rem_nz);
        tail_size         <= rem_nz ? SIZE_W'(rem) : SIZE_W'(PAYLOAD_BYTES);
        acked_count       <= '0;
        outstanding_count <= '0;
        next_seq          <= seq_r;
        expected_seq      <= seq_r;
        phase             <= PH_SEND;
      end
      if (cmd.do_ack && in_range) begin
        acked_count       <= acked_count + COUNT_W'(ack_step);
        outstanding_count <= outstanding_count - ack_step;
        expected_seq      <= seq_r + SEQ_W'(1);
      end
      if (cmd.do_rewind) begin
        next_seq          <= next_seq - SEQ_W'(outstanding_count);
        outstanding_count <= '0;
      end
      if (cmd.emit_data) begin
        outstanding_count <= out_inc[WIN_W-1:0];
        next_seq          <= next_seq + SEQ_W'(1);
      end
      if (cmd.emit_fin) phase <= PH_FIN;
      if (cmd.go_idle) phase <= PH_IDLE;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_data || cmd.emit_fin) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_data) begin
      pkt_kind    <= KIND_DATA;
      seq_out     <= next_seq;
      chunk_index <= chunk[CHUNK_W-1:0];
      pay_len     <= chunk_size;
      last        <= status.send_last;
    end else if (cmd.emit_fin) begin
      pkt_kind    <= KIND_FIN;
      seq_out     <= '0;
      chunk_index <= '0;
      pay_len     <= '0;
      last        <= 1'b1;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/go_back_n_sender_window_top.sv */
// top level of the go-back-n sender window: config port, controller and datapath
`default_nettype none

// Go-Back-N sender window control. A setup transaction (req_type 0) gives the
// start sequence and file size; the block cuts the file into 1024-byte chunks
// and issues one data-send descriptor (sequence, chunk index, size) per cycle
// while the output is not held, until window_size packets are in flight. An
// in-range cumulative ack slides the window and refills it, a timeout rewinds
// to the oldest unacked packet and resends the window, and once every chunk is
// acked a FIN descriptor goes out. In FIN wait a timeout resends the FIN and a
// receiver FIN returns to idle. The last descriptor caused by an input
// transaction carries last = 1. One input transaction is handled at a time: it
// is taken in, then decoded; an ack then passes a state for the window compare
// and slide; then the emit loop sends the descriptors, or ends when it finds
// nothing to send. The emit loop stalls while the output register is held.
// The next input is taken right after the last descriptor is loaded into the
// output register, even while that descriptor still waits.
// window_size lives at byte address 0 of the APB-style port and resets to 1;
// 0 acts as 1 and values above MAX_WIN (64 by default) act as MAX_WIN.

module go_back_n_sender_window_top #(
  parameter int MAX_WIN = gbns_pkg::MAX_WINDOW
) (
  input  wire                               clk,
  input  wire                               rst,
  // configuration port
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [gbns_pkg::ADDR_W-1:0]       paddr,
  input  wire  [gbns_pkg::DATA_W-1:0]       pwdata,
  output logic [gbns_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  // input channel
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  [gbns_pkg::REQ_W-1:0]        req_type,
  input  wire  [gbns_pkg::SEQ_W-1:0]        seq,
  input  wire  [gbns_pkg::SEQ_W-1:0]        xfer_len,
  // output channel
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic                              pkt_kind,
  output logic [gbns_pkg::SEQ_W-1:0]        seq_out,
  output logic [gbns_pkg::CHUNK_W-1:0]      chunk_index,
  output logic [gbns_pkg::SIZE_W-1:0]       pay_len,
  output logic                              last
);
  import gbns_pkg::*;

  gbns_cmd_t        cmd;
  gbns_status_t     status;
  logic             cfg_we;
  logic [WIN_W-1:0] window_size;

  // register index is the word address bit
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE);

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_WINDOW_SIZE) prdata = DATA_W'(window_size);
  end

  gbns_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  gbns_dp #(
    .MAX_WIN (MAX_WIN)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_wdata   (pwdata[WIN_W-1:0]),
    .window_size (window_size),
    .req_type    (req_type),
    .seq         (seq),
    .xfer_len    (xfer_len),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pkt_kind    (pkt_kind),
    .seq_out     (seq_out),
    .chunk_index (chunk_index),
    .pay_len     (pay_len),
    .last        (last)
  );

endmodule

`default_nettype wire

/* bench/go_back_n_sender_window_top_test.sv */
// self-checking testbench of the go-back-n sender window top level
`timescale 1ns / 100ps

module go_back_n_sender_window_top_test;
  import gbns_pkg::*;

  // run length and pacing
  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE       = 80;   // covers the longest refill of a 64-packet window
  localparam int HOLD_CYCLES  = 300;  // long receiver hold-off, fills the block up
  localparam int N_SEGS       = 7;
  localparam int SEG_ITEMS    = 43;

  localparam logic [SEQ_W-1:0] SEQ_TOP = '1;

  // one send descriptor as the output channel shows it
  typedef struct packed {
    logic               kind;
    logic [SEQ_W-1:0]   sq;
    logic [CHUNK_W-1:0] chunk;
    logic [SIZE_W-1:0]  size;
    logic               last;
  } pkt_t;

  // one directed request; typed rows carry their single result (or none) by hand
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic [SEQ_W-1:0] sq;
    logic [SEQ_W-1:0] fsz;
    logic             typed;
    logic             n_out;
    pkt_t             pkt;
  } step_row_t;

  localparam pkt_t FIN_PKT = '{KIND_FIN, 31'd0, 21'd0, 11'd0, 1'b1};
  localparam pkt_t NO_PKT  = '0;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // block inputs, all known from time zero
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [ADDR_W-1:0]   paddr     = '0;
  logic [DATA_W-1:0]   pwdata    = '0;
  logic                in_valid  = 1'b0;
  logic [REQ_W-1:0]    req_type  = REQ_SETUP;
  logic [SEQ_W-1:0]    seq       = '0;
  logic [SEQ_W-1:0]    xfer_len  = '0;
  logic                out_stall = 1'b0;

  // block outputs
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_stall;
  logic                out_valid;
  logic                pkt_kind;
  logic [SEQ_W-1:0]    seq_out;
  logic [CHUNK_W-1:0]  chunk_index;
  logic [SIZE_W-1:0]   pay_len;
  logic                last;

  go_back_n_sender_window_top DUT (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .seq         (seq),
    .xfer_len    (xfer_len),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pkt_kind    (pkt_kind),
    .seq_out     (seq_out),
    .chunk_index (chunk_index),
    .pay_len     (pay_len),
    .last        (last)
  );

  // ---------------------------------------------------------------------------
  // sender model: its own copy of the window register and of the block's state
  // ---------------------------------------------------------------------------
  logic [WIN_W-1:0]  win_reg   = 7'd1;
  gbns_phase_t       ph        = PH_IDLE;
  int unsigned       n_chunks  = 0;
  int unsigned       n_acked   = 0;
  int unsigned       in_flight = 0;
  logic [SEQ_W-1:0]  next_sq   = '0;
  logic [SEQ_W-1:0]  oldest_sq = '0;
  logic [SIZE_W-1:0] tail      = '0;

  pkt_t burst [$];     // descriptors caused by the request being modeled
  pkt_t due_pkts [$];  // descriptors still owed by the block, oldest first

  function automatic void put_pkt(logic kind, logic [SEQ_W-1:0] s, int unsigned ch,
                                  int unsigned sz);
    pkt_t p;
    p.kind  = kind;
    p.sq    = s;
    p.chunk = CHUNK_W'(ch);
    p.size  = SIZE_W'(sz);
    p.last  = 1'b0;
    burst.push_back(p);
  endfunction

  // refill the window, or send the FIN once every chunk is acked
  function automatic void fill_window();
    int unsigned w;
    int unsigned ch;
    w = (win_reg == 0) ? 1 : ((win_reg > MAX_WINDOW) ? MAX_WINDOW : int'(win_reg));
    if (n_acked >= n_chunks) begin
      put_pkt(KIND_FIN, '0, 0, 0);
      ph = PH_FIN;
      return;
    end
    while (in_flight < w && n_acked + in_flight < n_chunks) begin
      ch = n_acked + in_flight;
      put_pkt(KIND_DATA, next_sq, ch, (ch + 1 < n_chunks) ? PAYLOAD_BYTES : int'(tail));
      in_flight++;
      next_sq = next_sq + 1'b1;
    end
  endfunction

  // models one accepted request into burst; returns 0 when the block ignores it
  function automatic bit sender_step(logic [REQ_W-1:0] req, logic [SEQ_W-1:0] sq,
                                     logic [SEQ_W-1:0] fsz);
    logic [SEQ_W-1:0] d;
    int unsigned rem;
    bit acted;
    burst.delete();
    acted = 1'b0;
    case (ph)
      PH_IDLE: begin
        if (req == REQ_SETUP) begin
          rem       = fsz % PAYLOAD_BYTES;
          n_chunks  = fsz / PAYLOAD_BYTES + ((rem != 0) ? 1 : 0);
          tail      = (rem != 0) ? SIZE_W'(rem) : SIZE_W'(PAYLOAD_BYTES);
          n_acked   = 0;
          in_flight = 0;
          next_sq   = sq;
          oldest_sq = sq;
          ph        = PH_SEND;
          acted     = 1'b1;
          fill_window();
        end
      end
      PH_SEND: begin
        if (req == REQ_ACK) begin
          // cumulative ack, distance taken modulo the sequence space
          d = sq - oldest_sq;
          if (d < in_flight) begin
            n_acked   += d + 1;
            in_flight -= d + 1;
            oldest_sq  = sq + 1'b1;
          end
        end else if (req == REQ_TIMEOUT) begin
          // rewind to the oldest unacked packet
          next_sq   = next_sq - SEQ_W'(in_flight);
          in_flight = 0;
        end
        if (req != REQ_SETUP) begin
          acted = 1'b1;
          fill_window();
        end
      end
      default: begin
        if (req == REQ_TIMEOUT) begin
          put_pkt(KIND_FIN, '0, 0, 0);
          acted = 1'b1;
        end else if (req == REQ_FIN) begin
          ph    = PH_IDLE;
          acted = 1'b1;
        end
      end
    endcase
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    return acted;
  endfunction

  // ---------------------------------------------------------------------------
  // output side: receiver stalls in bursts, checks every descriptor
  // ---------------------------------------------------------------------------
  bit calm     = 1'b0;  // no idling on either side
  bit hold_out = 1'b0;  // request for the long hold-off

  int n_bad    = 0;
  int n_pkts   = 0;
  int n_fins   = 0;
  int n_cycles = 0;

  always begin
    @(negedge clk);
    if (hold_out) begin
      out_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      out_stall <= 1'b0;
      hold_out = 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      out_stall <= 1'b0;
    end else begin
      // stretch with no stall
      repeat ($urandom_range(0, 9)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    pkt_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_pkts.size() == 0) begin
        $error("unexpected descriptor: pkt_kind %0d seq_out %0h chunk_index %0d",
               pkt_kind, seq_out, chunk_index);
        n_bad++;
      end else begin
        want = due_pkts.pop_front();
        n_pkts++;
        if (pkt_kind == KIND_FIN) n_fins++;
        if (pkt_kind !== want.kind) begin
          $error("pkt_kind: expected %0d actual %0d", want.kind, pkt_kind);
          n_bad++;
        end
        if (seq_out !== want.sq) begin
          $error("seq_out: expected %0h actual %0h", want.sq, seq_out);
          n_bad++;
        end
        if (chunk_index !== want.chunk) begin
          $error("chunk_index: expected %0d actual %0d", want.chunk, chunk_index);
          n_bad++;
        end
        if (pay_len !== want.size) begin
          $error("pay_len: expected %0d actual %0d", want.size, pay_len);
          n_bad++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d actual %0d", want.last, last);
          n_bad++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d descriptors still owed", n_cycles,
               due_pkts.size());
      $display("go_back_n_sender_window_top_test: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  bit   use_fixed = 1'b0;  // directed row with a hand-typed result
  bit   fixed_n   = 1'b0;
  pkt_t fixed_pkt = '0;

  int n_sent    = 0;
  int n_live    = 0;  // requests the block acts on
  int n_windows = 0;

  // one request transaction; starts and ends just after a falling edge
  task automatic offer(input logic [REQ_W-1:0] req, input logic [SEQ_W-1:0] sq,
                       input logic [SEQ_W-1:0] fsz);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= req;
    seq       <= sq;
    xfer_len  <= fsz;
    do @(posedge clk); while (in_stall);
    if (sender_step(req, sq, fsz)) n_live++;
    n_sent++;
    if (use_fixed) begin
      if (fixed_n) due_pkts.push_back(fixed_pkt);
    end else begin
      foreach (burst[i]) due_pkts.push_back(burst[i]);
    end
    @(negedge clk);
  endtask

  // wait for every owed descriptor, then for a possible silent request in flight
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_pkts.size() != 0);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  // register write: setup cycle then access cycle, only while the block is quiet
  task automatic set_window(input logic [DATA_W-1:0] v);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * REG_WINDOW_SIZE);
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    win_reg = v[WIN_W-1:0];
    n_windows++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // random request shaped by where the transfer stands
  function automatic void pick_item(output logic [REQ_W-1:0] req,
                                    output logic [SEQ_W-1:0] sq,
                                    output logic [SEQ_W-1:0] fsz);
    int unsigned r;
    int unsigned k;
    r   = $urandom_range(0, 99);
    k   = $urandom_range(0, 99);
    req = REQ_ACK;
    sq  = SEQ_W'($urandom);
    fsz = SEQ_W'($urandom);
    case (ph)
      PH_IDLE: begin
        if (r < 85) begin
          req = REQ_SETUP;
          if ($urandom_range(0, 3) == 0) sq = SEQ_TOP - SEQ_W'($urandom_range(0, 80));
          // mostly small files, some exact multiples, a few long ones
          if (k < 8) begin
            fsz = '0;
          end else if (k < 22) begin
            fsz = SEQ_W'($urandom_range(1, 8) * PAYLOAD_BYTES);
          end else if (k < 32) begin
            fsz = SEQ_W'($urandom_range(60, 150) * PAYLOAD_BYTES +
                         $urandom_range(0, PAYLOAD_BYTES - 1));
          end else begin
            fsz = SEQ_W'($urandom_range(0, 9) * PAYLOAD_BYTES +
                         $urandom_range(1, PAYLOAD_BYTES - 1));
          end
        end else begin
          req = REQ_W'($urandom_range(REQ_ACK, REQ_FIN));
        end
      end
      PH_SEND: begin
        if (r < 66 && in_flight > 0) begin
          sq = oldest_sq + SEQ_W'($urandom_range(0, in_flight - 1));
        end else if (r < 78) begin
          req = REQ_TIMEOUT;
        end else if (r < 84) begin
          // just past the window
          sq = oldest_sq + SEQ_W'(in_flight + $urandom_range(0, 3));
        end else if (r < 88) begin
          sq = oldest_sq - 1'b1;
        end else if (r < 94) begin
          req = REQ_FIN;
        end else begin
          req = REQ_SETUP;
        end
      end
      default: begin
        if (r < 55) req = REQ_FIN;
        else if (r < 80) req = REQ_TIMEOUT;
        else req = REQ_W'($urandom_range(REQ_SETUP, REQ_ACK));
      end
    endcase
  endfunction

  // directed part, walked with the reset window of one packet
  step_row_t dir_rows [25] = '{
    // idle ignores everything but a setup
    '{REQ_ACK,     31'd5,          31'd0,          1'b1, 1'b0, NO_PKT},
    '{REQ_TIMEOUT, 31'd0,          31'h7FFF_FFFF,  1'b1, 1'b0, NO_PKT},
    '{REQ_FIN,     31'h7FFF_FFFF,  31'd0,          1'b1, 1'b0, NO_PKT},
    // empty file goes straight to the FIN
    '{REQ_SETUP,   31'h7FFF_FFFF,  31'd0,          1'b1, 1'b1, FIN_PKT},
    // fin wait ignores setups and acks, resends the FIN on timeout
    '{REQ_SETUP,   31'd3,          31'd100,        1'b1, 1'b0, NO_PKT},
    '{REQ_ACK,     31'd0,          31'd0,          1'b1, 1'b0, NO_PKT},
    '{REQ_TIMEOUT, 31'd0,          31'd0,          1'b1, 1'b1, FIN_PKT},
    '{REQ_FIN,     31'd0,          31'd0,          1'b1, 1'b0, NO_PKT},
    // one-byte file at the top of the sequence space
    '{REQ_SETUP,   31'h7FFF_FFFF,  31'd1,          1'b1, 1'b1,
      '{KIND_DATA, 31'h7FFF_FFFF, 21'd0, 11'd1, 1'b1}},
    '{REQ_ACK,     31'h7FFF_FFFE,  31'd0,          1'b1, 1'b0, NO_PKT},
    '{REQ_FIN,     31'd0,          31'd0,          1'b1, 1'b0, NO_PKT},
    '{REQ_SETUP,   31'd0,          31'd5000,       1'b1, 1'b0, NO_PKT},
    '{REQ_ACK,     31'h7FFF_FFFF,  31'd0,          1'b1, 1'b1, FIN_PKT},
    '{REQ_FIN,     31'd0,          31'd0,          1'b1, 1'b0, NO_PKT},
    // three chunks across the sequence wrap, with timeouts on both sides of it
    '{REQ_SETUP,   31'h7FFF_FFFE,  31'd3000,       1'b1, 1'b1,
      '{KIND_DATA, 31'h7FFF_FFFE, 21'd0, 11'd1024, 1'b1}},
    '{REQ_TIMEOUT, 31'd0,          31'd0,          1'b1, 1'b1,
      '{KIND_DATA, 31'h7FFF_FFFE, 21'd0, 11'd1024, 1'b1}},
    '{REQ_ACK,     31'h7FFF_FFFE,  31'd0,          1'b1, 1'b1,
      '{KIND_DATA, 31'h7FFF_FFFF, 21'd1, 11'd1024, 1'b1}},
    '{REQ_ACK,     31'h7FFF_FFFF,  31'd0,          1'b1, 1'b1,
      '{KIND_DATA, 31'd0, 21'd2, 11'd952, 1'b1}},
    '{REQ_TIMEOUT, 31'd0,          31'd0,          1'b1, 1'b1,
      '{KIND_DATA, 31'd0, 21'd2, 11'd952, 1'b1}},
    '{REQ_ACK,     31'd0,          31'd0,          1'b1, 1'b1, FIN_PKT},
    '{REQ_TIMEOUT, 31'd0,          31'd0,          1'b1, 1'b1, FIN_PKT},
    '{REQ_FIN,     31'd0,          31'd0,          1'b1, 1'b0, NO_PKT},
    // exact multiple of the chunk size, left to the model
    '{REQ_SETUP,   31'd0,          31'd2048,       1'b0, 1'b0, NO_PKT},
    '{REQ_ACK,     31'd0,          31'd0,          1'b0, 1'b0, NO_PKT},
    '{REQ_ACK,     31'd1,          31'd0,          1'b0, 1'b0, NO_PKT}
  };

  initial begin
    logic [REQ_W-1:0]  r_req;
    logic [SEQ_W-1:0]  r_sq;
    logic [SEQ_W-1:0]  r_fsz;
    logic [DATA_W-1:0] wv;
    bit held;
    held = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed rows
    foreach (dir_rows[i]) begin
      use_fixed = dir_rows[i].typed;
      fixed_n   = dir_rows[i].n_out;
      fixed_pkt = dir_rows[i].pkt;
      offer(dir_rows[i].req, dir_rows[i].sq, dir_rows[i].fsz);
    end
    use_fixed = 1'b0;

    // random segments, each under its own window setting
    for (int s = 0; s < N_SEGS; s++) begin
      case (s)
        0:       wv = 32'd127;  // caps at the largest window
        1:       wv = 32'd0;    // acts as a window of one
        2:       wv = MAX_WINDOW;
        3:       wv = 32'd1;
        4:       wv = $urandom_range(2, 16);
        5:       wv = 32'hFFFF_FF80 | $urandom_range(1, 127);  // junk above the field
        default: wv = 32'd5;
      endcase
      set_window(wv);
      if (s == N_SEGS - 1) calm = 1'b1;
      n_live = 0;
      while (n_live < SEG_ITEMS) begin
        // one long receiver hold-off while requests keep coming
        if (s == 0 && !held && ph == PH_IDLE && n_live >= 5) begin
          hold_out = 1'b1;
          held     = 1'b1;
        end
        pick_item(r_req, r_sq, r_fsz);
        offer(r_req, r_sq, r_fsz);
      end
    end

    // finish the transfer, then open the largest possible file
    while (ph != PH_IDLE) begin
      if (ph == PH_SEND) offer(REQ_ACK, oldest_sq + SEQ_W'(in_flight - 1), SEQ_W'($urandom));
      else offer(REQ_FIN, SEQ_W'($urandom), SEQ_W'($urandom));
    end
    offer(REQ_SETUP, SEQ_W'($urandom), SEQ_TOP);
    for (int i = 0; i < 6; i++) begin
      if (i == 3) offer(REQ_TIMEOUT, SEQ_W'($urandom), SEQ_W'($urandom));
      else offer(REQ_ACK, oldest_sq + SEQ_W'($urandom_range(0, in_flight - 1)), '0);
    end

    drain();

    $display("%0d request transactions under %0d window settings, one %0d-cycle output hold",
             n_sent, n_windows, HOLD_CYCLES);
    $display("%0d send descriptors checked, %0d of them FIN", n_pkts, n_fins);
    if (n_bad == 0) begin
      $display("go_back_n_sender_window_top_test: clean");
    end else begin
      $display("go_back_n_sender_window_top_test: errors");
    end
    $finish;
  end

endmodule
